FILE: rtl/core/oap_pkg.sv
// shared types, constants and step functions for the orient-and-place pipeline
// no dependencies
`default_nettype none

package oap_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int CW_EFF = (COORD_WIDTH < 16) ? 16 : ((COORD_WIDTH > 32) ? 32 : COORD_WIDTH);

    localparam int SQ_STEPS  = 31;
    localparam int SQ_W      = 2 * SQ_STEPS;
    localparam int DIV_STEPS = 17;
    localparam int DIV_W     = 48;

    localparam logic [SQ_W-1:0]  SQ_ONE  = 1;
    localparam logic [DIV_W-1:0] DIV_ONE = 1;
    localparam logic [DIV_STEPS-1:0] Q_ONE = 1;
    localparam logic [DIV_STEPS-1:0] Q_UNIT = 17'd32768;
    localparam logic signed [16:0] UNIT = 17'sd32768;

    localparam logic signed [34:0] SAT_HI = 35'((64'd1 << (CW_EFF - 1)) - 64'd1);
    localparam logic signed [34:0] SAT_LO = -SAT_HI - 35'sd1;

    typedef struct packed {
        logic signed [15:0] dx;
        logic signed [15:0] dy;
        logic signed [15:0] dz;
        logic signed [31:0] sh_x;
        logic signed [31:0] sh_y;
        logic signed [31:0] sh_z;
        logic signed [31:0] rf_x;
        logic signed [31:0] rf_y;
        logic signed [31:0] rf_z;
    } item_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DIV_W-1:0]     rem;
        logic [DIV_STEPS-1:0] q;
    } dv_t;

    typedef struct packed {
        logic [15:0] sth;
        logic [30:0] rs;
        logic        flat;
    } trig_t;

    typedef struct packed {
        logic [15:0]          sth;
        logic [DIV_STEPS-1:0] qx;
        logic [DIV_STEPS-1:0] qy;
        logic                 flat;
    } ratio_t;

    function automatic sq_t sqrt_step(sq_t cur, logic [SQ_W-1:0] bit_v);
        sq_t nx;
        logic [SQ_W-1:0] trial;
        trial = cur.root + bit_v;
        if (cur.rem >= trial) begin
            nx.rem  = cur.rem - trial;
            nx.root = (cur.root >> 1) + bit_v;
        end else begin
            nx.rem  = cur.rem;
            nx.root = cur.root >> 1;
        end
        return nx;
    endfunction

    function automatic dv_t div_step(dv_t cur, logic [DIV_W-1:0] sub_v,
                                     logic [DIV_STEPS-1:0] qbit);
        dv_t nx;
        if (cur.rem >= sub_v) begin
            nx.rem = cur.rem - sub_v;
            nx.q   = cur.q | qbit;
        end else begin
            nx = cur;
        end
        return nx;
    endfunction

    function automatic logic signed [31:0] sext_coord(logic [31:0] v);
        logic signed [31:0] t;
        t = v << (32 - CW_EFF);
        return t >>> (32 - CW_EFF);
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/orient_and_place_point.sv
// orient_and_place_point: rotates a reference point by an orientation vector and adds an offset
// made of 32 square root stages, 18 divider stages and 5 matrix and output stages
// throughput one beat per cycle; the whole pipeline advances when the output register is free
// reset clears the stage valid bits only; no clearing pass, payload registers are not reset
// depends on oap_pkg, oap_sqrt, oap_div, oap_place
`default_nettype none

module orient_and_place_point (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [15:0] s_dir_x,
    input  wire logic [15:0] s_dir_y,
    input  wire logic [15:0] s_dir_z,
    input  wire logic [31:0] s_shift_x,
    input  wire logic [31:0] s_shift_y,
    input  wire logic [31:0] s_shift_z,
    input  wire logic [31:0] s_ref_x,
    input  wire logic [31:0] s_ref_y,
    input  wire logic [31:0] s_ref_z,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_pos_x,
    output logic [31:0]      m_pos_y,
    output logic [31:0]      m_pos_z
);
    import oap_pkg::*;

    logic   en;
    item_t  in_item, sq_item, dv_item;
    trig_t  sq_trig;
    ratio_t dv_ratio;
    logic   sq_valid, dv_valid;

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    always_comb begin
        in_item.dx   = $signed(s_dir_x);
        in_item.dy   = $signed(s_dir_y);
        in_item.dz   = $signed(s_dir_z);
        in_item.sh_x = sext_coord(s_shift_x);
        in_item.sh_y = sext_coord(s_shift_y);
        in_item.sh_z = sext_coord(s_shift_z);
        in_item.rf_x = sext_coord(s_ref_x);
        in_item.rf_y = sext_coord(s_ref_y);
        in_item.rf_z = sext_coord(s_ref_z);
    end

    oap_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_item   (in_item),
        .out_valid (sq_valid),
        .out_item  (sq_item),
        .out_trig  (sq_trig)
    );

    oap_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_item   (sq_item),
        .in_trig   (sq_trig),
        .out_valid (dv_valid),
        .out_item  (dv_item),
        .out_ratio (dv_ratio)
    );

    oap_place u_place (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .in_item   (dv_item),
        .in_ratio  (dv_ratio),
        .out_valid (m_valid),
        .pos_x     (m_pos_x),
        .pos_y     (m_pos_y),
        .pos_z     (m_pos_z)
    );

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pos_x) && $stable(m_pos_y)
                                && $stable(m_pos_z))
        else $error("stalled result changed");

    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |-> !s_ready)
        else $error("input taken while output stalled");

endmodule

`default_nettype wire

FILE: rtl/core/oap_sqrt.sv
// square root pipeline: sin theta and horizontal length, one result bit per stage
// depends on oap_pkg
`default_nettype none

module oap_sqrt (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire oap_pkg::item_t in_item,
    output logic                out_valid,
    output oap_pkg::item_t      out_item,
    output oap_pkg::trig_t      out_trig
);
    import oap_pkg::*;

    logic [SQ_STEPS:0] vld_reg;
    item_t item_reg [SQ_STEPS+1];
    sq_t   th_reg   [SQ_STEPS+1];
    sq_t   rs_reg   [SQ_STEPS+1];
    logic  flat_reg [SQ_STEPS+1];

    logic signed [31:0] dxsq, dysq, dzsq;
    logic [31:0] r2, nth;

    always_comb begin
        dxsq = in_item.dx * in_item.dx;
        dysq = in_item.dy * in_item.dy;
        dzsq = in_item.dz * in_item.dz;
        r2   = 32'(dxsq) + 32'(dysq);
        nth  = 32'h4000_0000 - 32'(dzsq);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQ_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            th_reg[0]   <= '{rem: SQ_W'(nth), root: '0};
            rs_reg[0]   <= '{rem: {r2, 30'b0}, root: '0};
            flat_reg[0] <= (r2 == 32'd0);
            for (int s = 0; s < SQ_STEPS; s++) begin
                item_reg[s+1] <= item_reg[s];
                flat_reg[s+1] <= flat_reg[s];
                th_reg[s+1]   <= sqrt_step(th_reg[s], SQ_ONE << (2 * (SQ_STEPS - 1 - s)));
                rs_reg[s+1]   <= sqrt_step(rs_reg[s], SQ_ONE << (2 * (SQ_STEPS - 1 - s)));
            end
        end
    end

    assign out_valid     = vld_reg[SQ_STEPS];
    assign out_item      = item_reg[SQ_STEPS];
    assign out_trig.sth  = th_reg[SQ_STEPS].root[15:0];
    assign out_trig.rs   = rs_reg[SQ_STEPS].root[30:0];
    assign out_trig.flat = flat_reg[SQ_STEPS];

endmodule

`default_nettype wire

FILE: rtl/core/oap_div.sv
// restoring divider pipeline: |dir_x| and |dir_y| over the horizontal length
// depends on oap_pkg
`default_nettype none

module oap_div (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           en,
    input  wire logic           in_valid,
    input  wire oap_pkg::item_t in_item,
    input  wire oap_pkg::trig_t in_trig,
    output logic                out_valid,
    output oap_pkg::item_t      out_item,
    output oap_pkg::ratio_t     out_ratio
);
    import oap_pkg::*;

    logic [DIV_STEPS:0] vld_reg;
    item_t            item_reg [DIV_STEPS+1];
    logic [DIV_W-1:0] den_reg  [DIV_STEPS+1];
    logic [15:0]      sth_reg  [DIV_STEPS+1];
    logic             flat_reg [DIV_STEPS+1];
    dv_t              x_reg    [DIV_STEPS+1];
    dv_t              y_reg    [DIV_STEPS+1];

    logic [15:0] absx, absy;

    always_comb begin
        absx = in_item.dx[15] ? 16'(-in_item.dx) : 16'(in_item.dx);
        absy = in_item.dy[15] ? 16'(-in_item.dy) : 16'(in_item.dy);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg[0] <= in_item;
            den_reg[0]  <= in_trig.flat ? DIV_ONE : DIV_W'(in_trig.rs);
            sth_reg[0]  <= in_trig.sth;
            flat_reg[0] <= in_trig.flat;
            x_reg[0]    <= '{rem: {2'b0, absx, 30'b0}, q: '0};
            y_reg[0]    <= '{rem: {2'b0, absy, 30'b0}, q: '0};
            for (int s = 0; s < DIV_STEPS; s++) begin
                item_reg[s+1] <= item_reg[s];
                den_reg[s+1]  <= den_reg[s];
                sth_reg[s+1]  <= sth_reg[s];
                flat_reg[s+1] <= flat_reg[s];
                x_reg[s+1] <= div_step(x_reg[s], den_reg[s] << (DIV_STEPS - 1 - s),
                                       Q_ONE << (DIV_STEPS - 1 - s));
                y_reg[s+1] <= div_step(y_reg[s], den_reg[s] << (DIV_STEPS - 1 - s),
                                       Q_ONE << (DIV_STEPS - 1 - s));
            end
        end
    end

    assign out_valid      = vld_reg[DIV_STEPS];
    assign out_item       = item_reg[DIV_STEPS];
    assign out_ratio.sth  = sth_reg[DIV_STEPS];
    assign out_ratio.qx   = x_reg[DIV_STEPS].q;
    assign out_ratio.qy   = y_reg[DIV_STEPS].q;
    assign out_ratio.flat = flat_reg[DIV_STEPS];

endmodule

`default_nettype wire

FILE: rtl/core/oap_place.sv
// rotation matrix, matrix-vector product, floor, offset add and saturation
// depends on oap_pkg
`default_nettype none

module oap_place (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire oap_pkg::item_t  in_item,
    input  wire oap_pkg::ratio_t in_ratio,
    output logic                 out_valid,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   pos_z
);
    import oap_pkg::*;

    logic [4:0] vld_reg;

    // stage a: signed unit ratios
    item_t              a_item_reg;
    logic signed [16:0] cphi_reg, sphi_reg, sth_reg;
    // stage b: matrix
    logic signed [31:0] m_reg [3][3];
    logic signed [31:0] b_rf_reg [3];
    logic signed [31:0] b_sh_reg [3];
    // stage c: products
    logic signed [63:0] p_reg [3][3];
    logic signed [31:0] c_sh_reg [3];
    // stage d: floored rows
    logic signed [33:0] fl_reg [3];
    logic signed [31:0] d_sh_reg [3];
    // stage e: output
    logic signed [31:0] pos_reg [3];

    logic [DIV_STEPS-1:0] qxc, qyc;
    logic signed [16:0]   cphi_next, sphi_next, cth;
    logic signed [63:0]   acc [3];
    logic signed [34:0]   sum [3];

    always_comb begin
        qxc = (in_ratio.qx > Q_UNIT) ? Q_UNIT : in_ratio.qx;
        qyc = (in_ratio.qy > Q_UNIT) ? Q_UNIT : in_ratio.qy;
        cphi_next = in_item.dx[15] ? -$signed(qxc) : $signed(qxc);
        sphi_next = in_item.dy[15] ? -$signed(qyc) : $signed(qyc);
        if (in_ratio.flat) begin
            cphi_next = UNIT;
            sphi_next = '0;
        end
        cth = 17'(a_item_reg.dz);
        for (int i = 0; i < 3; i++) begin
            acc[i] = p_reg[i][0] + p_reg[i][1] + p_reg[i][2];
            sum[i] = 35'(fl_reg[i]) + 35'(d_sh_reg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[3:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_item_reg <= in_item;
            cphi_reg   <= cphi_next;
            sphi_reg   <= sphi_next;
            sth_reg    <= $signed({1'b0, in_ratio.sth});

            m_reg[0][0] <= 32'(cphi_reg) <<< 15;
            m_reg[0][1] <= 32'(sphi_reg) <<< 15;
            m_reg[0][2] <= '0;
            m_reg[1][0] <= 32'(-(sphi_reg * cth));
            m_reg[1][1] <= 32'(cphi_reg * cth);
            m_reg[1][2] <= 32'(sth_reg) <<< 15;
            m_reg[2][0] <= 32'(sphi_reg * sth_reg);
            m_reg[2][1] <= 32'(-(cphi_reg * sth_reg));
            m_reg[2][2] <= 32'(cth) <<< 15;
            b_rf_reg[0] <= a_item_reg.rf_x;
            b_rf_reg[1] <= a_item_reg.rf_y;
            b_rf_reg[2] <= a_item_reg.rf_z;
            b_sh_reg[0] <= a_item_reg.sh_x;
            b_sh_reg[1] <= a_item_reg.sh_y;
            b_sh_reg[2] <= a_item_reg.sh_z;

            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p_reg[i][j] <= 64'(m_reg[i][j]) * 64'(b_rf_reg[j]);
                end
                c_sh_reg[i] <= b_sh_reg[i];
                fl_reg[i]   <= 34'(acc[i] >>> 30);
                d_sh_reg[i] <= c_sh_reg[i];
                if (sum[i] > SAT_HI) begin
                    pos_reg[i] <= 32'(SAT_HI);
                end else if (sum[i] < SAT_LO) begin
                    pos_reg[i] <= 32'(SAT_LO);
                end else begin
                    pos_reg[i] <= 32'(sum[i]);
                end
            end
        end
    end

    assign out_valid = vld_reg[4];
    assign pos_x     = pos_reg[0];
    assign pos_y     = pos_reg[1];
    assign pos_z     = pos_reg[2];

endmodule

`default_nettype wire
